[design/mie_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mie_pkg
// shared types and constants of the modular inverse block
// ----------------------------------------------------------------------------
package mie_pkg;
	localparam int DataWidthDef = 64;
	localparam int ModWidth = 63;
	localparam logic [ModWidth-1:0] ModulusReset = 63'd65537;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED_START,
		ST_RED_WAIT,
		ST_RED_FIX,
		ST_LOOP_TEST,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_MUL,
		ST_UPDATE,
		ST_FINAL,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		DIV_SRC_REDUCE,
		DIV_SRC_EUCLID,
		DIV_SRC_FINAL
	} div_src_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_src_t div_src;
		logic     red_fix;
		logic     mul;
		logic     update;
		logic     finish;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic mod_zero;
		logic a_zero;
	} dp_stat_t;
endpackage
`default_nettype wire

[design/modular_inverse_ext_euclid.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// modular inverse of a signed word by the extended euclidean algorithm
// ----------------------------------------------------------------------------
// the result follows the reduction divide, one bit-serial divide and multiply per
// euclid quotient step (up to about 92 at 64 bits) and a final divide; a zero
// modulus skips straight to the output. one word at a time, next word accepted
// after the result is taken. asynchronous reset returns to idle, modulus 65537
module modular_inverse_ext_euclid #(
	parameter int DATA_WIDTH = mie_pkg::DataWidthDef
) (
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,
	input  wire  logic                          cfg_we,
	input  wire  logic [mie_pkg::ModWidth-1:0]  cfg_wdata,
	input  wire  logic                          s_tvalid,
	output logic                                s_tready,
	input  wire  logic [DATA_WIDTH-1:0]         s_tdata,   // value
	output logic                                m_tvalid,
	input  wire  logic                          m_tready,
	output logic [mie_pkg::ModWidth:0]          m_tdata,   // inverse, zero pad
	output logic                                m_tuser    // no_inverse
);
	import mie_pkg::*;

	logic [ModWidth-1:0] modulus_q;
	logic [ModWidth-1:0] inverse;
	dp_cmd_t             cmd;
	dp_stat_t            stat;
	logic                mul_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			modulus_q <= ModulusReset;
		else if (cfg_we)
			modulus_q <= cfg_wdata;
	end

	mie_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.s_ready(s_tready), .m_valid(m_tvalid), .m_ready(m_tready),
		.stat(stat), .mul_done(mul_done), .cmd(cmd)
	);

	mie_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .mul_done(mul_done),
		.value(s_tdata), .modulus(modulus_q), .inverse(inverse), .no_inverse(m_tuser)
	);

	assign m_tdata = {1'b0, inverse};
endmodule
`default_nettype wire

[design/mie_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mie_div
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mie_div #(
	parameter int W = 64
) (
	input  wire  logic         clk,
	input  wire  logic         arst_n,
	input  wire  logic         start,
	input  wire  logic [W-1:0] dividend,
	input  wire  logic [W-1:0] divisor,
	output logic               done,
	output logic [W-1:0]       quotient,
	output logic [W-1:0]       remainder
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		trial   = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

[design/mie_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mie_mul
// shift-add multiplier, one multiplier bit per cycle, low word kept
// ----------------------------------------------------------------------------
module mie_mul #(
	parameter int W = 64
) (
	input  wire  logic         clk,
	input  wire  logic         arst_n,
	input  wire  logic         start,
	input  wire  logic [W-1:0] op_a,
	input  wire  logic [W-1:0] op_b,
	output logic               done,
	output logic [W-1:0]       product
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  acc_q, a_q, b_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= op_a;
			b_q   <= op_b;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_q;
			a_q <= {a_q[W-2:0], 1'b0};
			b_q <= {1'b0, b_q[W-1:1]};
		end
	end

	assign product = acc_q;
endmodule
`default_nettype wire

[design/mie_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mie_datapath
// operand registers, divider shared by reduction, euclid loop and final step, multiplier of the loop
// ----------------------------------------------------------------------------
module mie_datapath #(
	parameter int DATA_WIDTH = mie_pkg::DataWidthDef
) (
	input  wire  logic                    clk,
	input  wire  logic                    arst_n,
	input  wire  mie_pkg::dp_cmd_t        cmd,
	output mie_pkg::dp_stat_t             stat,
	output logic                          mul_done,
	input  wire  logic [DATA_WIDTH-1:0]   value,
	input  wire  logic [mie_pkg::ModWidth-1:0] modulus,
	output logic [mie_pkg::ModWidth-1:0]  inverse,
	output logic                          no_inverse
);
	import mie_pkg::*;
	localparam int W = DATA_WIDTH;

	logic [W-1:0] m_q, g_q, a_q, xm_q, ym_q, q_q, val_q;
	logic         xneg_q, yneg_q;
	logic [W-1:0] dvd, dvs, quo, rem, prod, mag;
	logic         div_done;

	always_comb begin
		mag = val_q[W-1] ? (W'(0) - val_q) : val_q;
		case (cmd.div_src)
			DIV_SRC_REDUCE: begin
				dvd = mag;
				dvs = m_q;
			end
			DIV_SRC_EUCLID: begin
				dvd = g_q;
				dvs = a_q;
			end
			DIV_SRC_FINAL: begin
				dvd = xm_q;
				dvs = m_q;
			end
			default: begin
				dvd = g_q;
				dvs = a_q;
			end
		endcase
	end

	mie_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dvd), .divisor(dvs), .done(div_done),
		.quotient(quo), .remainder(rem)
	);

	mie_mul #(.W(W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.mul),
		.op_a(q_q), .op_b(ym_q), .done(mul_done), .product(prod)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q  <= value;
			m_q    <= W'(modulus[W-2:0]);
			xm_q   <= '0;
			xneg_q <= 1'b0;
			ym_q   <= W'(1);
			yneg_q <= 1'b0;
		end
		if (cmd.red_fix) begin
			g_q   <= m_q;
			a_q   <= (val_q[W-1] && rem != '0) ? (m_q - rem) : rem;
		end
		if (div_done && cmd.div_src == DIV_SRC_EUCLID)
			q_q <= quo;
		if (cmd.update) begin
			g_q    <= a_q;
			a_q    <= rem;
			xm_q   <= ym_q;
			xneg_q <= yneg_q;
			ym_q   <= xm_q + prod;
			yneg_q <= !yneg_q;
		end
		if (cmd.finish) begin
			if (m_q == '0 || g_q != W'(1)) begin
				inverse    <= '0;
				no_inverse <= 1'b1;
			end else begin
				inverse    <= ModWidth'((xneg_q && rem != '0) ? (m_q - rem) : rem);
				no_inverse <= 1'b0;
			end
		end
		if (cmd.load && modulus[W-2:0] == '0) begin
			inverse    <= '0;
			no_inverse <= 1'b1;
		end
	end

	assign stat.div_done = div_done;
	assign stat.mod_zero = (m_q == '0);
	assign stat.a_zero   = (a_q == '0);
endmodule
`default_nettype wire

[design/mie_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mie_ctrl
// sequencer of the input accept, reduction, euclid iterations, final reduction and output handshake
// ----------------------------------------------------------------------------
module mie_ctrl (
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	input  wire  logic              in_fire,
	output logic                    s_ready,
	output logic                    m_valid,
	input  wire  logic              m_ready,
	input  wire  mie_pkg::dp_stat_t stat,
	input  wire  logic              mul_done,
	output mie_pkg::dp_cmd_t        cmd
);
	import mie_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_src = DIV_SRC_EUCLID;
		s_ready     = 1'b0;
		m_valid     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d  = ST_RED_START;
				end
			end
			ST_RED_START: begin
				if (stat.mod_zero)
					state_d = ST_OUT;
				else begin
					cmd.div_src   = DIV_SRC_REDUCE;
					cmd.div_start = 1'b1;
					state_d       = ST_RED_WAIT;
				end
			end
			ST_RED_WAIT: begin
				cmd.div_src = DIV_SRC_REDUCE;
				if (stat.div_done)
					state_d = ST_RED_FIX;
			end
			ST_RED_FIX: begin
				cmd.red_fix = 1'b1;
				state_d     = ST_LOOP_TEST;
			end
			ST_LOOP_TEST: begin
				if (stat.a_zero) begin
					cmd.div_src   = DIV_SRC_FINAL;
					cmd.div_start = 1'b1;
					state_d       = ST_FINAL;
				end else
					state_d = ST_DIV_START;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (mul_done) begin
					cmd.update = 1'b1;
					state_d    = ST_LOOP_TEST;
				end
			end
			ST_FINAL: begin
				cmd.div_src = DIV_SRC_FINAL;
				if (stat.div_done) begin
					cmd.finish = 1'b1;
					state_d    = ST_OUT;
				end
			end
			ST_OUT: begin
				m_valid = 1'b1;
				if (m_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// streaming testbench of the modular inverse block: words of random and edge
// operands go in under several moduli, each result is checked against an
// extended euclid predictor, with random gaps on the input and output sides
// ----------------------------------------------------------------------------
module tb_top;
	import mie_pkg::*;

	localparam int DW = 64;
	localparam longint unsigned CycleLimit = 64'd25_000_000;

	typedef struct packed {
		logic [ModWidth-1:0] inverse;
		logic                no_inverse;
	} inv_res_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [ModWidth-1:0] cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [DW-1:0]       s_tdata;   // value
	logic                m_tvalid;
	logic                m_tready;
	logic [ModWidth:0]   m_tdata;   // inverse, zero pad
	logic                m_tuser;   // no_inverse

	logic [DW-1:0]       operand_q[$];
	inv_res_t            inverse_q[$];
	logic [ModWidth-1:0] cur_modulus;
	int                  fail_cnt;
	longint unsigned     cycle_cnt;
	int                  in_gap;
	int                  out_stall;
	logic                out_took;
	logic                in_took;
	logic                no_gaps;

	modular_inverse_ext_euclid #(.DATA_WIDTH(DW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic inv_res_t modular_inverse(input logic [DW-1:0] v);
		bit [63:0] m, a, g, q, nr, xm, ym, nym, r;
		bit        xneg, yneg;
		inv_res_t  res;
		m = {1'b0, cur_modulus};
		res = '0;
		if (m == 0) begin
			res.no_inverse = 1'b1;
			return res;
		end
		if (v[63]) begin
			a = (64'd0 - v) % m;
			if (a != 0)
				a = m - a;
		end else begin
			a = v % m;
		end
		g = m;
		xm = 0;
		xneg = 0;
		ym = 1;
		yneg = 0;
		while (a != 0) begin
			q = g / a;
			nr = g - q * a;
			nym = xm + q * ym;
			g = a;
			a = nr;
			xm = ym;
			xneg = yneg;
			ym = nym;
			yneg = !yneg;
		end
		if (g != 1) begin
			res.no_inverse = 1'b1;
			return res;
		end
		r = xm % m;
		if (xneg && r != 0)
			r = m - r;
		res.inverse = r[ModWidth-1:0];
		return res;
	endfunction

	task automatic queue_operand(input logic [DW-1:0] v);
		operand_q = {operand_q, v};
	endtask

	// input side: cycle limit, accept and predict
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
		in_took <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			inverse_q = {inverse_q, modular_inverse(s_tdata)};
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !in_took) begin
				// hold the word
			end else if (in_gap > 0) begin
				s_tvalid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (operand_q.size() > 0) begin
				s_tdata <= operand_q.pop_front();
				s_tvalid <= 1'b1;
				in_gap <= no_gaps ? 0 : $urandom_range(0, 14);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		inv_res_t exp_r;
		out_took <= arst_n && m_tvalid && m_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (inverse_q.size() == 0) begin
				$error("result word with no expectation: inverse %0d no_inverse %0d",
					m_tdata, m_tuser);
				fail_cnt = fail_cnt + 1;
			end else begin
				exp_r = inverse_q.pop_front();
				if (m_tdata !== {1'b0, exp_r.inverse}) begin
					$error("inverse: expected %0d actual %0d", exp_r.inverse, m_tdata);
					fail_cnt = fail_cnt + 1;
				end
				if (m_tuser !== exp_r.no_inverse) begin
					$error("no_inverse: expected %0d actual %0d", exp_r.no_inverse, m_tuser);
					fail_cnt = fail_cnt + 1;
				end
			end
		end
	end

	// output back-pressure
	always @(negedge clk) begin
		int s;
		s = out_stall;
		if (out_took)
			s = no_gaps ? 0 : $urandom_range(0, 14);
		if (s > 0) begin
			m_tready <= 1'b0;
			s = s - 1;
		end else begin
			m_tready <= 1'b1;
		end
		out_stall <= s;
	end

	task automatic wait_idle();
		while (operand_q.size() != 0 || inverse_q.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_modulus(input logic [ModWidth-1:0] mv);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mv;
		cur_modulus = mv;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_operands(input int n_rand);
		logic [DW-1:0] m64, v;
		m64 = {1'b0, cur_modulus};
		// edge operands
		queue_operand(64'd0);
		queue_operand(64'd1);
		queue_operand({DW{1'b1}});
		queue_operand({1'b1, 63'd0});
		queue_operand({1'b0, {63{1'b1}}});
		queue_operand(m64 - 64'd1);
		queue_operand(64'd0 - m64);
		for (int i = 0; i < n_rand; i++) begin
			if (i % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: v = {$urandom, $urandom};
				1: v = 64'($urandom_range(0, 1000));
				2: v = 64'd0 - 64'($urandom_range(0, 1000));
				default: v = m64 * $urandom_range(0, 5) + $urandom_range(0, 3);
			endcase
			queue_operand(v);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cur_modulus = ModulusReset;
		fail_cnt = 0;
		cycle_cnt = 0;
		in_gap = 0;
		out_stall = 0;
		out_took = 1'b0;
		in_took = 1'b0;
		no_gaps = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_operand(64'd65536);
		queue_operand(64'd65537);
		queue_operand(64'd65538);
		load_operands(60);
		set_modulus(63'd2);
		load_operands(25);
		set_modulus(63'd1);
		load_operands(15);
		set_modulus(63'd0);
		load_operands(15);
		set_modulus(63'd3);
		load_operands(25);
		set_modulus(63'd97);
		load_operands(55);
		set_modulus(63'd1000);
		load_operands(55);
		set_modulus({63{1'b1}});
		load_operands(25);
		set_modulus(63'h1FFF_FFFF_FFFF_FFFF);
		load_operands(25);
		for (int k = 0; k < 6; k++) begin
			set_modulus(63'($urandom_range(2, 65535)));
			load_operands(35);
		end
		set_modulus(63'({$urandom, $urandom} >> 1));
		load_operands(20);

		wait_idle();
		repeat (200) @(posedge clk);
		if (fail_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
